@@ hdl/sms_pkg.sv @@
package sms_pkg;

   localparam int unsigned MIN_REPLY_BYTES = 4;
   localparam int unsigned RX_LEN_W        = 5;
   localparam int unsigned CSR_INDEX_W     = 3;

   localparam logic [7:0] STATUS_INVALID_BIT = 8'h80;
   localparam logic [RX_LEN_W-1:0] MIN_REPLY_LEN = RX_LEN_W'(MIN_REPLY_BYTES);

   localparam logic [7:0] MEASURE_COMMAND_RST = 8'd170;
   localparam logic [7:0] BUSY_MASK_RST       = 8'd32;
   localparam logic [7:0] FAULT_MASK_RST      = 8'd7;
   localparam logic [7:0] POWERED_MASK_RST    = 8'd64;
   localparam logic [7:0] MODE_MASK_RST       = 8'd24;
   localparam logic [7:0] MODE_RESERVED_RST   = 8'd16;

   localparam logic [CSR_INDEX_W-1:0] REG_MEASURE_COMMAND = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BUSY_MASK       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FAULT_MASK      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_POWERED_MASK    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE_MASK       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE_RESERVED   = 3'd5;

   typedef enum logic [2:0] {
      CMD_DUE        = 3'd0,
      CMD_START      = 3'd1,
      CMD_EOC        = 3'd2,
      CMD_READ       = 3'd3,
      CMD_POLL       = 3'd4,
      CMD_COMPLETION = 3'd5,
      CMD_TIMEOUT    = 3'd6,
      CMD_TAKE       = 3'd7
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_SLEEP    = 4'd1,
      PH_STARTING = 4'd2,
      PH_WAIT_EOC = 4'd3,
      PH_READING  = 4'd4,
      PH_POLLING  = 4'd5,
      PH_RECOVERY = 4'd6,
      PH_READY    = 4'd7,
      PH_TIMEOUT  = 4'd8
   } phase_type;

   typedef struct packed {
      logic [7:0] measure_command;
      logic [7:0] busy_mask;
      logic [7:0] fault_mask;
      logic [7:0] powered_mask;
      logic [7:0] mode_mask;
      logic [7:0] mode_reserved;
   } cfg_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  fsm_state;
      logic [7:0]  tx_command;
      logic        raw_ready_event;
      logic [7:0]  out_status;
      logic [23:0] out_raw;
      logic [31:0] out_sequence;
      logic [31:0] out_version;
      logic [63:0] out_sample_us;
      logic [63:0] out_completion_us;
      logic        out_usable;
      logic [31:0] error_total;
   } rsp_type;

   function automatic logic status_usable(input logic [7:0] status, input cfg_type cfg);
      logic [7:0] bad;
      bad = cfg.busy_mask | cfg.fault_mask;
      return ((status & STATUS_INVALID_BIT) == 8'd0) &&
             ((status & cfg.powered_mask) != 8'd0) &&
             ((status & bad) == 8'd0) &&
             ((status & cfg.mode_mask) != cfg.mode_reserved);
   endfunction

endpackage

@@ hdl/sms_channels.sv @@
interface sms_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] corr_id;
   logic [31:0] trans_id;
   logic        success;
   logic [7:0]  rx_status;
   logic [23:0] rx_raw;
   logic [4:0]  rx_len;
   logic [63:0] now_us;

   modport source (output valid, cmd, corr_id, trans_id, success, rx_status, rx_raw,
                   rx_len, now_us, input ready);
   modport sink (input valid, cmd, corr_id, trans_id, success, rx_status, rx_raw,
                 rx_len, now_us, output ready);
endinterface

interface sms_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [3:0]  fsm_state;
   logic [7:0]  tx_command;
   logic        raw_ready_event;
   logic [7:0]  out_status;
   logic [23:0] out_raw;
   logic [31:0] out_sequence;
   logic [31:0] out_version;
   logic [63:0] out_sample_us;
   logic [63:0] out_completion_us;
   logic        out_usable;
   logic [31:0] error_total;

   modport source (output valid, ok, fsm_state, tx_command, raw_ready_event, out_status,
                   out_raw, out_sequence, out_version, out_sample_us, out_completion_us,
                   out_usable, error_total, input ready);
   modport sink (input valid, ok, fsm_state, tx_command, raw_ready_event, out_status,
                 out_raw, out_sequence, out_version, out_sample_us, out_completion_us,
                 out_usable, error_total, output ready);
endinterface

interface sms_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/sms_csr.sv @@
module sms_csr (
   input  logic             clock,
   input  logic             reset,
   sms_csr_if.sink          csr_ch,
   output sms_pkg::cfg_type cfg
);
   import sms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_MEASURE_COMMAND: cfg_in.measure_command = csr_ch.data;
            REG_BUSY_MASK:       cfg_in.busy_mask       = csr_ch.data;
            REG_FAULT_MASK:      cfg_in.fault_mask      = csr_ch.data;
            REG_POWERED_MASK:    cfg_in.powered_mask    = csr_ch.data;
            REG_MODE_MASK:       cfg_in.mode_mask       = csr_ch.data;
            REG_MODE_RESERVED:   cfg_in.mode_reserved   = csr_ch.data;
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.measure_command <= MEASURE_COMMAND_RST;
         cfg_ff.busy_mask       <= BUSY_MASK_RST;
         cfg_ff.fault_mask      <= FAULT_MASK_RST;
         cfg_ff.powered_mask    <= POWERED_MASK_RST;
         cfg_ff.mode_mask       <= MODE_MASK_RST;
         cfg_ff.mode_reserved   <= MODE_RESERVED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/sensor_measurement_sequencer_core.sv @@
// Channel   Direction  Handshake            Transaction
// req_ch    in         valid/ready          one sequencer event
// rsp_ch    out        valid/ready          one result per event
// csr_ch    in         valid/ready (ready=1) one register write
//
// One event per cycle while req_ch.ready is high; its result is registered.
// The state update and the result are one pass of logic between the event and the
// result register; a skid register takes one result while the output stalls.
// req_ch.ready is low only while the skid register holds a result.
// Synchronous active-high reset clears phase, the active correlation id, counters and the mailbox flag.
module sensor_measurement_sequencer_core (
   input logic     clock,
   input logic     reset,
   sms_req_if.sink req_ch,
   sms_rsp_if.source rsp_ch,
   sms_csr_if.sink csr_ch
);
   import sms_pkg::*;

   cfg_type cfg;

   sms_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   phase_type   phase_ff, phase_in;
   logic [31:0] active_corr_ff, active_corr_in;
   logic [31:0] sequence_count_ff, sequence_count_in;
   logic [31:0] ready_count_ff, ready_count_in;
   logic [31:0] err_total_ff, err_total_in;
   logic [63:0] request_time_ff, request_time_in;
   logic        mbox_valid_ff, mbox_valid_in;
   logic        mbox_load;
   logic [7:0]  mbox_status_ff;
   logic [23:0] mbox_raw_ff;
   logic [31:0] mbox_sequence_ff;
   logic [31:0] mbox_version_ff;
   logic [63:0] mbox_sample_ff;
   logic [63:0] mbox_done_ff;
   logic        mbox_usable_ff;

   rsp_type     result;
   rsp_type     out_ff, out_in;
   rsp_type     skid_ff, skid_in;
   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   logic        req_fire;
   logic        out_free;

   assign req_ch.ready = !skid_valid_ff;
   assign req_fire     = req_ch.valid && !skid_valid_ff;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      phase_in          = phase_ff;
      active_corr_in    = active_corr_ff;
      sequence_count_in = sequence_count_ff;
      ready_count_in    = ready_count_ff;
      err_total_in      = err_total_ff;
      request_time_in   = request_time_ff;
      mbox_valid_in     = mbox_valid_ff;
      mbox_load         = 1'b0;
      result            = '0;

      case (cmd_type'(req_ch.cmd))
         CMD_DUE: begin
            if (phase_ff == PH_IDLE || phase_ff == PH_SLEEP) begin
               phase_in        = PH_STARTING;
               request_time_in = req_ch.now_us;
               mbox_valid_in   = 1'b0;
            end
         end
         CMD_START: begin
            if (phase_ff == PH_STARTING && req_ch.corr_id != 32'd0 &&
                req_ch.trans_id != 32'd0) begin
               active_corr_in    = req_ch.corr_id;
               sequence_count_in = sequence_count_ff + 32'd1;
               result.ok         = 1'b1;
               result.tx_command = cfg.measure_command;
            end
         end
         CMD_EOC: phase_in = PH_READING;
         CMD_READ: result.ok = (phase_ff == PH_READING || phase_ff == PH_POLLING);
         CMD_POLL: phase_in = PH_POLLING;
         CMD_COMPLETION: begin
            if (req_ch.corr_id != active_corr_ff) begin
               err_total_in = err_total_ff + 32'd1;
            end else if (!req_ch.success) begin
               err_total_in = err_total_ff + 32'd1;
               phase_in     = PH_RECOVERY;
            end else if (phase_ff == PH_STARTING) begin
               phase_in = PH_WAIT_EOC;
            end else if ((phase_ff != PH_READING && phase_ff != PH_POLLING) ||
                         req_ch.rx_len < MIN_REPLY_LEN) begin
               err_total_in = err_total_ff + 32'd1;
               phase_in     = PH_RECOVERY;
            end else if ((req_ch.rx_status & cfg.busy_mask) != 8'd0) begin
               phase_in = PH_POLLING;
            end else begin
               mbox_load              = 1'b1;
               mbox_valid_in          = 1'b1;
               ready_count_in         = ready_count_ff + 32'd1;
               phase_in               = PH_READY;
               result.raw_ready_event = 1'b1;
            end
         end
         CMD_TIMEOUT: begin
            mbox_valid_in = 1'b0;
            phase_in      = PH_TIMEOUT;
         end
         CMD_TAKE: begin
            if (mbox_valid_ff) begin
               result.ok                = 1'b1;
               result.out_status        = mbox_status_ff;
               result.out_raw           = mbox_raw_ff;
               result.out_sequence      = mbox_sequence_ff;
               result.out_version       = mbox_version_ff;
               result.out_sample_us     = mbox_sample_ff;
               result.out_completion_us = mbox_done_ff;
               result.out_usable        = mbox_usable_ff;
               mbox_valid_in            = 1'b0;
               phase_in                 = PH_IDLE;
            end
         end
         default: phase_in = phase_ff;
      endcase

      result.fsm_state   = 4'(phase_in);
      result.error_total = err_total_in;
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = req_fire;
         end
      end else if (req_fire) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         active_corr_ff    <= '0;
         sequence_count_ff <= '0;
         ready_count_ff    <= '0;
         err_total_ff      <= '0;
         request_time_ff   <= '0;
         mbox_valid_ff     <= 1'b0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff          <= phase_in;
            active_corr_ff    <= active_corr_in;
            sequence_count_ff <= sequence_count_in;
            ready_count_ff    <= ready_count_in;
            err_total_ff      <= err_total_in;
            request_time_ff   <= request_time_in;
            mbox_valid_ff     <= mbox_valid_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (req_fire && mbox_load) begin
         mbox_status_ff   <= req_ch.rx_status;
         mbox_raw_ff      <= req_ch.rx_raw;
         mbox_sequence_ff <= sequence_count_ff;
         mbox_version_ff  <= ready_count_ff + 32'd1;
         mbox_sample_ff   <= request_time_ff;
         mbox_done_ff     <= req_ch.now_us;
         mbox_usable_ff   <= status_usable(req_ch.rx_status, cfg);
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.ok                = out_ff.ok;
   assign rsp_ch.fsm_state         = out_ff.fsm_state;
   assign rsp_ch.tx_command        = out_ff.tx_command;
   assign rsp_ch.raw_ready_event   = out_ff.raw_ready_event;
   assign rsp_ch.out_status        = out_ff.out_status;
   assign rsp_ch.out_raw           = out_ff.out_raw;
   assign rsp_ch.out_sequence      = out_ff.out_sequence;
   assign rsp_ch.out_version       = out_ff.out_version;
   assign rsp_ch.out_sample_us     = out_ff.out_sample_us;
   assign rsp_ch.out_completion_us = out_ff.out_completion_us;
   assign rsp_ch.out_usable        = out_ff.out_usable;
   assign rsp_ch.error_total       = out_ff.error_total;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a transaction while output is empty");

   a_err_idle_stable: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(err_total_ff))
      else $error("error count moved without an accepted transaction");

   a_err_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (err_total_ff == $past(err_total_ff)) ||
                   (err_total_ff == $past(err_total_ff) + 32'd1))
      else $error("error count stepped by more than one");

   a_ready_event_phase: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.raw_ready_event) |-> (out_ff.fsm_state == 4'(PH_READY)))
      else $error("sample latched without entering ready");
`endif

endmodule

@@ tb/sms_scoreboard_pkg.sv @@
package sms_scoreboard_pkg;

   import sms_pkg::*;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] corr_id;
      logic [31:0] trans_id;
      logic        success;
      logic [7:0]  rx_status;
      logic [23:0] rx_raw;
      logic [4:0]  rx_len;
      logic [63:0] now_us;
   } sms_event_type;

   class measurement_scoreboard;
      cfg_type     cfg;
      phase_type   phase;
      logic [31:0] active_corr;
      logic [31:0] active_trans;
      logic [31:0] sample_count;
      logic [31:0] ready_count;
      logic [31:0] err_total;
      logic [63:0] request_time;
      logic        mbox_valid;
      logic        mbox_usable;
      logic [7:0]  mbox_status;
      logic [23:0] mbox_raw;
      logic [31:0] mbox_sequence;
      logic [31:0] mbox_version;
      logic [63:0] mbox_sample_time;
      logic [63:0] mbox_done_time;
      rsp_type     pending_results[$];
      int unsigned mismatches;

      function new();
         cfg.measure_command = MEASURE_COMMAND_RST;
         cfg.busy_mask       = BUSY_MASK_RST;
         cfg.fault_mask      = FAULT_MASK_RST;
         cfg.powered_mask    = POWERED_MASK_RST;
         cfg.mode_mask       = MODE_MASK_RST;
         cfg.mode_reserved   = MODE_RESERVED_RST;
         phase            = PH_IDLE;
         active_corr      = '0;
         active_trans     = '0;
         sample_count     = '0;
         ready_count      = '0;
         err_total        = '0;
         request_time     = '0;
         mbox_valid       = 1'b0;
         mbox_usable      = 1'b0;
         mbox_status      = '0;
         mbox_raw         = '0;
         mbox_sequence    = '0;
         mbox_version     = '0;
         mbox_sample_time = '0;
         mbox_done_time   = '0;
         mismatches       = 0;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [7:0] data);
         case (index)
            REG_MEASURE_COMMAND: cfg.measure_command = data;
            REG_BUSY_MASK:       cfg.busy_mask = data;
            REG_FAULT_MASK:      cfg.fault_mask = data;
            REG_POWERED_MASK:    cfg.powered_mask = data;
            REG_MODE_MASK:       cfg.mode_mask = data;
            REG_MODE_RESERVED:   cfg.mode_reserved = data;
            default: ;
         endcase
      endfunction

      function logic reading_usable(logic [7:0] s);
         return ((s & STATUS_INVALID_BIT) == 8'd0) &&
                ((s & cfg.powered_mask) != 8'd0) &&
                ((s & (cfg.busy_mask | cfg.fault_mask)) == 8'd0) &&
                ((s & cfg.mode_mask) != cfg.mode_reserved);
      endfunction

      function void note_event(sms_event_type ev);
         rsp_type r;
         r = '0;
         case (ev.cmd)
            CMD_DUE: begin
               if (phase == PH_IDLE || phase == PH_SLEEP) begin
                  phase        = PH_STARTING;
                  request_time = ev.now_us;
                  mbox_valid   = 1'b0;
               end
            end
            CMD_START: begin
               if (phase == PH_STARTING && ev.corr_id != 32'd0 && ev.trans_id != 32'd0) begin
                  active_corr  = ev.corr_id;
                  active_trans = ev.trans_id;
                  sample_count = sample_count + 32'd1;
                  r.ok         = 1'b1;
                  r.tx_command = cfg.measure_command;
               end
            end
            CMD_EOC: phase = PH_READING;
            CMD_READ: begin
               if (phase == PH_READING || phase == PH_POLLING) r.ok = 1'b1;
            end
            CMD_POLL: phase = PH_POLLING;
            CMD_COMPLETION: begin
               if (ev.corr_id != active_corr) begin
                  err_total = err_total + 32'd1;
               end else if (!ev.success) begin
                  err_total = err_total + 32'd1;
                  phase     = PH_RECOVERY;
               end else if (phase == PH_STARTING) begin
                  phase = PH_WAIT_EOC;
               end else if ((phase != PH_READING && phase != PH_POLLING) ||
                            ev.rx_len < MIN_REPLY_LEN) begin
                  err_total = err_total + 32'd1;
                  phase     = PH_RECOVERY;
               end else if ((ev.rx_status & cfg.busy_mask) != 8'd0) begin
                  phase = PH_POLLING;
               end else begin
                  mbox_status      = ev.rx_status;
                  mbox_raw         = ev.rx_raw;
                  mbox_sequence    = sample_count;
                  mbox_version     = ready_count + 32'd1;
                  mbox_sample_time = request_time;
                  mbox_done_time   = ev.now_us;
                  mbox_usable      = reading_usable(ev.rx_status);
                  mbox_valid       = 1'b1;
                  ready_count      = ready_count + 32'd1;
                  phase            = PH_READY;
                  r.raw_ready_event = 1'b1;
               end
            end
            CMD_TIMEOUT: begin
               mbox_valid = 1'b0;
               phase      = PH_TIMEOUT;
            end
            default: begin
               if (mbox_valid) begin
                  r.ok                = 1'b1;
                  r.out_status        = mbox_status;
                  r.out_raw           = mbox_raw;
                  r.out_sequence      = mbox_sequence;
                  r.out_version       = mbox_version;
                  r.out_sample_us     = mbox_sample_time;
                  r.out_completion_us = mbox_done_time;
                  r.out_usable        = mbox_usable;
                  mbox_valid          = 1'b0;
                  phase               = PH_IDLE;
               end
            end
         endcase
         r.fsm_state   = phase;
         r.error_total = err_total;
         pending_results.push_back(r);
      endfunction

      function bit field_differs(string name, logic [63:0] want, logic [63:0] got);
         if (want === got) return 1'b0;
         if (mismatches < 10)
            $display("mismatch on %s: expected %0h actual %0h", name, want, got);
         return 1'b1;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         bit      bad;
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result transaction, state %0d", got.fsm_state);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         bad = 1'b0;
         bad |= field_differs("ok", 64'(want.ok), 64'(got.ok));
         bad |= field_differs("fsm_state", 64'(want.fsm_state), 64'(got.fsm_state));
         bad |= field_differs("tx_command", 64'(want.tx_command), 64'(got.tx_command));
         bad |= field_differs("raw_ready_event", 64'(want.raw_ready_event),
                              64'(got.raw_ready_event));
         bad |= field_differs("out_status", 64'(want.out_status), 64'(got.out_status));
         bad |= field_differs("out_raw", 64'(want.out_raw), 64'(got.out_raw));
         bad |= field_differs("out_sequence", 64'(want.out_sequence),
                              64'(got.out_sequence));
         bad |= field_differs("out_version", 64'(want.out_version), 64'(got.out_version));
         bad |= field_differs("out_sample_us", want.out_sample_us, got.out_sample_us);
         bad |= field_differs("out_completion_us", want.out_completion_us,
                              got.out_completion_us);
         bad |= field_differs("out_usable", 64'(want.out_usable), 64'(got.out_usable));
         bad |= field_differs("error_total", 64'(want.error_total), 64'(got.error_total));
         if (bad) mismatches++;
      endfunction
   endclass

endpackage

@@ tb/sensor_measurement_sequencer_core_tb.sv @@
module sensor_measurement_sequencer_core_tb;

   import sms_pkg::*;
   import sms_scoreboard_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_ITEMS = 100;

   logic clock;
   logic reset;

   sms_req_if req_ch();
   sms_rsp_if rsp_ch();
   sms_csr_if csr_ch();

   measurement_scoreboard sb = new();

   int unsigned send_idle   = 0;
   int unsigned recv_idle   = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left   = 0;
   int unsigned events_sent = 0;
   bit          hold_armed  = 1'b0;
   bit          hold_done   = 1'b0;
   logic [63:0] now_base    = 64'd1000;
   rsp_type     seen;

   sensor_measurement_sequencer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // hold off once for a long stretch so the skid fills and input stalls
   always @(posedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_done     <= 1'b1;
         hold_left     <= 300;
         rsp_ch.ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.ok                = rsp_ch.ok;
         seen.fsm_state         = rsp_ch.fsm_state;
         seen.tx_command        = rsp_ch.tx_command;
         seen.raw_ready_event   = rsp_ch.raw_ready_event;
         seen.out_status        = rsp_ch.out_status;
         seen.out_raw           = rsp_ch.out_raw;
         seen.out_sequence      = rsp_ch.out_sequence;
         seen.out_version       = rsp_ch.out_version;
         seen.out_sample_us     = rsp_ch.out_sample_us;
         seen.out_completion_us = rsp_ch.out_completion_us;
         seen.out_usable        = rsp_ch.out_usable;
         seen.error_total       = rsp_ch.error_total;
         sb.check_result(seen);
      end
   end

   task automatic send_event(sms_event_type ev);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= ev.cmd;
      req_ch.corr_id   <= ev.corr_id;
      req_ch.trans_id  <= ev.trans_id;
      req_ch.success   <= ev.success;
      req_ch.rx_status <= ev.rx_status;
      req_ch.rx_raw    <= ev.rx_raw;
      req_ch.rx_len    <= ev.rx_len;
      req_ch.now_us    <= ev.now_us;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_event(ev);
      events_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [7:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.write_register(index, data);
   endtask

   task automatic write_config(cfg_type c);
      csr_write(REG_MEASURE_COMMAND, c.measure_command);
      csr_write(REG_BUSY_MASK, c.busy_mask);
      csr_write(REG_FAULT_MASK, c.fault_mask);
      csr_write(REG_POWERED_MASK, c.powered_mask);
      csr_write(REG_MODE_MASK, c.mode_mask);
      csr_write(REG_MODE_RESERVED, c.mode_reserved);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic sms_event_type event_of(cmd_type c, logic [31:0] corr,
                                              logic [31:0] trans, logic succ,
                                              logic [7:0] status, logic [23:0] raw,
                                              logic [4:0] len, logic [63:0] now);
      sms_event_type ev;
      ev.cmd       = c;
      ev.corr_id   = corr;
      ev.trans_id  = trans;
      ev.success   = succ;
      ev.rx_status = status;
      ev.rx_raw    = raw;
      ev.rx_len    = len;
      ev.now_us    = now;
      return ev;
   endfunction

   function automatic sms_event_type random_event(cmd_type c);
      sms_event_type ev;
      ev.cmd       = c;
      ev.corr_id   = $urandom;
      ev.trans_id  = $urandom;
      ev.success   = 1'($urandom_range(1));
      ev.rx_status = 8'($urandom);
      ev.rx_raw    = 24'($urandom);
      if ($urandom_range(9) == 0) ev.rx_len = 5'($urandom_range(31));
      else ev.rx_len = 5'($urandom_range(16));
      now_base = now_base + 64'($urandom_range(5000));
      if ($urandom_range(19) == 0) ev.now_us = {$urandom, $urandom};
      else ev.now_us = now_base;
      return ev;
   endfunction

   function automatic logic [7:0] reply_status(bit busy);
      logic [7:0] s;
      s = 8'($urandom);
      if ($urandom_range(1))
         s = (s & ~(sb.cfg.busy_mask | sb.cfg.fault_mask | STATUS_INVALID_BIT)) |
             sb.cfg.powered_mask;
      if (busy) s = s | sb.cfg.busy_mask;
      else if ($urandom_range(7) != 0) s = s & ~sb.cfg.busy_mask;
      return s;
   endfunction

   task automatic run_measurement();
      sms_event_type ev;
      logic [31:0]   corr;
      int unsigned   rounds;
      send_event(random_event(CMD_DUE));
      if ($urandom_range(9) == 0) begin
         ev = random_event(CMD_START);
         if ($urandom_range(1)) ev.corr_id = '0;
         else ev.trans_id = '0;
         send_event(ev);
      end
      ev = random_event(CMD_START);
      if (ev.corr_id == 0) ev.corr_id = 32'd1;
      if (ev.trans_id == 0) ev.trans_id = 32'd1;
      send_event(ev);
      corr = ev.corr_id;
      ev = random_event(CMD_COMPLETION);
      ev.corr_id = corr;
      ev.success = ($urandom_range(11) != 0);
      send_event(ev);
      if ($urandom_range(3) == 0) send_event(random_event(CMD_POLL));
      else send_event(random_event(CMD_EOC));
      if ($urandom_range(1)) send_event(random_event(CMD_READ));
      rounds = 0;
      do begin
         ev = random_event(CMD_COMPLETION);
         ev.corr_id = corr;
         ev.success = ($urandom_range(15) != 0);
         if ($urandom_range(15) == 0) ev.corr_id = corr ^ (32'd1 << $urandom_range(31));
         if ($urandom_range(15) == 0) ev.rx_len = 5'($urandom_range(3));
         else ev.rx_len = 5'($urandom_range(16, MIN_REPLY_BYTES));
         ev.rx_status = reply_status($urandom_range(3) == 0);
         send_event(ev);
         rounds++;
         if (sb.phase == PH_POLLING && $urandom_range(1)) begin
            if ($urandom_range(1)) send_event(random_event(CMD_POLL));
            else send_event(random_event(CMD_READ));
         end
      end while (sb.phase != PH_READY && sb.phase != PH_RECOVERY && rounds < 4);
      if (sb.phase == PH_READY) begin
         if ($urandom_range(7) == 0) send_event(random_event(CMD_TIMEOUT));
         send_event(random_event(CMD_TAKE));
         if ($urandom_range(3) == 0) send_event(random_event(CMD_TAKE));
      end
   endtask

   task automatic run_noise();
      int unsigned n;
      n = $urandom_range(5, 1);
      repeat (n) send_event(random_event(cmd_type'(3'($urandom_range(7)))));
   endtask

   function automatic cfg_type phase_config(int unsigned k);
      cfg_type c;
      case (k)
         0: c = '0;
         1: c = '1;
         2: begin
            c.measure_command = 8'($urandom);
            c.busy_mask       = 8'd1 << $urandom_range(7);
            c.fault_mask      = 8'($urandom) & ~c.busy_mask;
            c.powered_mask    = 8'd1 << $urandom_range(7);
            c.mode_mask       = 8'($urandom);
            c.mode_reserved   = 8'($urandom) & c.mode_mask;
         end
         3: c = 48'({$urandom, $urandom});
         default: begin
            c.measure_command = MEASURE_COMMAND_RST;
            c.busy_mask       = BUSY_MASK_RST;
            c.fault_mask      = FAULT_MASK_RST;
            c.powered_mask    = POWERED_MASK_RST;
            c.mode_mask       = MODE_MASK_RST;
            c.mode_reserved   = MODE_RESERVED_RST;
         end
      endcase
      return c;
   endfunction

   initial begin
      int unsigned start_count;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = '0;
      req_ch.corr_id   = '0;
      req_ch.trans_id  = '0;
      req_ch.success   = 1'b0;
      req_ch.rx_status = '0;
      req_ch.rx_raw    = '0;
      req_ch.rx_len    = '0;
      req_ch.now_us    = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle = 35;
      recv_idle = 86;
      send_event(event_of(CMD_TAKE, '0, '0, 1'b0, '0, '0, '0, '0));
      send_event(event_of(CMD_READ, '0, '0, 1'b0, '0, '0, '0, '0));
      send_event(event_of(CMD_START, 32'd1, 32'd1, 1'b0, '0, '0, '0, '0));
      send_event(event_of(CMD_COMPLETION, 32'd5, '0, 1'b1, '0, '0, 5'd4, '0));
      send_event(event_of(CMD_DUE, '0, '0, 1'b0, '0, '0, '0, '1));
      send_event(event_of(CMD_DUE, '0, '0, 1'b0, '0, '0, '0, 64'd7));
      send_event(event_of(CMD_START, 32'd0, 32'd7, 1'b0, '0, '0, '0, '0));
      send_event(event_of(CMD_START, 32'd7, 32'd0, 1'b0, '0, '0, '0, '0));
      send_event(event_of(CMD_START, '1, '1, 1'b1, '1, '1, '1, '1));
      send_event(event_of(CMD_COMPLETION, '1, '0, 1'b1, '0, '0, '0, 64'd20));
      send_event(event_of(CMD_EOC, '0, '0, 1'b0, '0, '0, '0, 64'd30));
      send_event(event_of(CMD_READ, '0, '0, 1'b0, '0, '0, '0, 64'd31));
      send_event(event_of(CMD_COMPLETION, '1, '0, 1'b1, 8'h20, 24'h123456, 5'd4, 64'd40));
      send_event(event_of(CMD_READ, '0, '0, 1'b0, '0, '0, '0, 64'd41));
      send_event(event_of(CMD_COMPLETION, '1, '0, 1'b1, 8'h48, '1, 5'd16, '0));
      send_event(event_of(CMD_TAKE, '0, '0, 1'b0, '0, '0, '0, 64'd50));
      send_event(event_of(CMD_TAKE, '0, '0, 1'b0, '0, '0, '0, 64'd51));
      send_event(event_of(CMD_POLL, '0, '0, 1'b0, '0, '0, '0, 64'd60));
      send_event(event_of(CMD_COMPLETION, '1, '0, 1'b1, 8'h48, '0, 5'd3, 64'd61));
      send_event(event_of(CMD_COMPLETION, '1, '0, 1'b0, 8'h48, '0, 5'd4, 64'd62));
      send_event(event_of(CMD_COMPLETION, '1, '0, 1'b1, 8'h48, '0, 5'd31, 64'd63));
      send_event(event_of(CMD_TIMEOUT, '0, '0, 1'b0, '0, '0, '0, 64'd70));
      send_event(event_of(CMD_EOC, '0, '0, 1'b0, '0, '0, '0, 64'd71));
      send_event(event_of(CMD_COMPLETION, '1, '0, 1'b1, 8'h90, '0, 5'd4, 64'd72));
      send_event(event_of(CMD_TIMEOUT, '0, '0, 1'b0, '0, '0, '0, 64'd80));
      send_event(event_of(CMD_TAKE, '0, '0, 1'b0, '0, '0, '0, 64'd81));

      for (int unsigned k = 0; k < 5; k++) begin
         drain();
         write_config(phase_config(k));
         if (k < 2) begin
            send_idle = 35;
            recv_idle = 86;
         end else if (k < 4) begin
            send_idle = 86;
            recv_idle = 35;
         end else begin
            send_idle  = 0;
            recv_idle  = 0;
            hold_armed = 1'b1;
         end
         start_count = events_sent;
         while (events_sent - start_count < PHASE_ITEMS) begin
            if ($urandom_range(4) == 0) run_noise();
            else run_measurement();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/sms_pkg.sv
hdl/sms_channels.sv
hdl/sms_csr.sv
hdl/sensor_measurement_sequencer_core.sv
tb/sms_scoreboard_pkg.sv
tb/sensor_measurement_sequencer_core_tb.sv
